// ===== sv/wbps_pkg.sv =====
// Shared types, constants and helpers for the wildcard byte pattern search.
// No dependencies; imported by every module of the block.
package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int WIN_DEPTH   = MAX_PATTERN - 1;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 32;
    localparam int PADDR_W     = 6;
    localparam int PDATA_W     = 64;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_PATTERN_LENGTH = 3'd2,
        REG_WILDCARD_BYTE  = 3'd3,
        REG_BASE_ADDRESS   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [63:0]       pattern_high;
        logic [63:0]       pattern_low;
        logic [LEN_W-1:0]  pattern_length;
        logic [7:0]        wildcard_byte;
        logic [ADDR_W-1:0] base_address;
    } cfg_t;

    // found sits in bit 0 when packed into the output tdata
    typedef struct packed {
        logic [ADDR_W-1:0] match_address;
        logic              found;
    } result_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // Inactive positions and wildcard pattern bytes always pass.
    function automatic logic byte_ok(input logic [7:0] data,
                                     input logic [7:0] pat,
                                     input logic [7:0] wild,
                                     input logic       active);
        return !active || (pat == wild) || (pat == data);
    endfunction

endpackage

// ===== sv/wbps_cell.sv =====
// One window cell: holds one past byte, compares its incoming byte.
// Depends on wbps_pkg.
module wbps_cell
    import wbps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] byte_in,
    input  logic [7:0] pat_byte,
    input  logic [7:0] wildcard_byte,
    input  logic       active,
    output logic [7:0] byte_out,
    output logic       ok
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb begin
        byte_next = byte_reg;
        if (ctrl.clear) begin
            byte_next = '0;
        end else if (ctrl.shift) begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign ok       = byte_ok(byte_in, pat_byte, wildcard_byte, active);

endmodule

// ===== sv/wbps_cfg.sv =====
// APB register file: pattern, length, wildcard byte, base address.
// Depends on wbps_pkg.
module wbps_cfg
    import wbps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[PADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_PATTERN_LOW:    cfg_next.pattern_low    = pwdata;
                REG_PATTERN_HIGH:   cfg_next.pattern_high   = pwdata;
                REG_PATTERN_LENGTH: cfg_next.pattern_length = pwdata[LEN_W-1:0];
                REG_WILDCARD_BYTE:  cfg_next.wildcard_byte  = pwdata[7:0];
                REG_BASE_ADDRESS:   cfg_next.base_address   = pwdata[ADDR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.pattern_length <= LEN_W'(1);
            cfg_reg.wildcard_byte  <= '0;
            cfg_reg.base_address   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_PATTERN_LOW:    prdata = cfg_reg.pattern_low;
            REG_PATTERN_HIGH:   prdata = cfg_reg.pattern_high;
            REG_PATTERN_LENGTH: prdata = PDATA_W'(cfg_reg.pattern_length);
            REG_WILDCARD_BYTE:  prdata = PDATA_W'(cfg_reg.wildcard_byte);
            REG_BASE_ADDRESS:   prdata = PDATA_W'(cfg_reg.base_address);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/wbps_skid.sv =====
// Two-entry output buffer (main register plus skid) for result transactions.
// Depends on wbps_pkg.
module wbps_skid
    import wbps_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg,  main_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    in_fire, out_fire, main_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = main_valid_reg && out_ready;
    assign main_free = !main_valid_reg || (out_ready && !skid_valid_reg);

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (in_fire && main_free) begin
            main_valid_next = 1'b1;
            main_data_next  = in_data;
        end else if (out_fire) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = 1'b0;
            end
        end
        if (in_fire && !main_free) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

// ===== sv/wildcard_byte_pattern_search_top.sv =====
// Wildcard byte pattern search, top level.
// Throughput: one byte transaction per cycle while s_tready is high, no gaps between regions.
// Result path: the result is registered in the output buffer (main register, or skid while main is stalled).
// Only an output stall with both buffer entries full (main + skid) drops s_tready.
// Reset: synchronous, active-low aresetn; clears window, offset, match state,
// output buffer, and loads register defaults (pattern length 1, rest zero).
module wildcard_byte_pattern_search_top
    import wbps_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tlast,   // last byte of the region
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] found, [32:1] match_address, rest 0
    // register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    cfg_t cfg;

    wbps_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Transaction qualifiers
    // ------------------------------------------------------------------
    logic s_fire;
    logic buf_ready;

    assign s_tready = buf_ready;
    assign s_fire   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Effective pattern length, clamped to the window size.
    // lenm1 is the distance from the match start back to the newest byte;
    // an empty pattern uses zero and matches at the current offset.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] len_c;
    logic [IDX_W-1:0] lenm1;
    logic [127:0]     pattern;

    assign len_c   = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                              : cfg.pattern_length;
    assign lenm1   = (len_c == '0) ? '0 : IDX_W'(len_c - LEN_W'(1));
    assign pattern = {cfg.pattern_high, cfg.pattern_low};

    // Per window position b (0 = current byte): active if b < length,
    // compared against pattern byte lenm1 - b.
    logic [7:0] pos_pat [MAX_PATTERN];
    logic       pos_act [MAX_PATTERN];

    always_comb begin
        logic [IDX_W-1:0] k;
        for (int b = 0; b < MAX_PATTERN; b++) begin
            k          = IDX_W'(lenm1 - IDX_W'(b));
            pos_act[b] = LEN_W'(b) < len_c;
            pos_pat[b] = pattern[8*k +: 8];
        end
    end

    // ------------------------------------------------------------------
    // Cell chain: cell i sees the byte at window position i and keeps it
    // for position i+1 on the next transaction. The last cell's stored byte
    // is the oldest position and is compared here.
    // ------------------------------------------------------------------
    cell_ctrl_t          cell_ctrl;
    logic [7:0]          chain   [WIN_DEPTH+1];
    logic [MAX_PATTERN-1:0] pos_ok;

    assign cell_ctrl.shift = s_fire && !s_tlast;
    assign cell_ctrl.clear = s_fire && s_tlast;
    assign chain[0]        = s_tdata[7:0];

    for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
        wbps_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (cell_ctrl),
            .byte_in       (chain[i]),
            .pat_byte      (pos_pat[i]),
            .wildcard_byte (cfg.wildcard_byte),
            .active        (pos_act[i]),
            .byte_out      (chain[i+1]),
            .ok            (pos_ok[i])
        );
    end

    assign pos_ok[MAX_PATTERN-1] = byte_ok(chain[WIN_DEPTH], pos_pat[MAX_PATTERN-1],
                                           cfg.wildcard_byte, pos_act[MAX_PATTERN-1]);

    // ------------------------------------------------------------------
    // Region state: saturating offset, first-match flag and address.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] offset_reg, offset_next;
    logic              seen_reg,   seen_next;
    logic [ADDR_W-1:0] first_reg,  first_next;
    logic [ADDR_W-1:0] cand_addr;
    logic              hit;

    // match start address, wraps mod 2^32
    assign cand_addr = cfg.base_address + offset_reg - ADDR_W'(lenm1);
    // a window hit counts only once the whole pattern lies inside the region
    assign hit       = !seen_reg && (offset_reg >= ADDR_W'(lenm1)) && (&pos_ok);

    always_comb begin
        offset_next = offset_reg;
        seen_next   = seen_reg;
        first_next  = first_reg;
        if (s_fire) begin
            if (s_tlast) begin
                offset_next = '0;
                seen_next   = 1'b0;
                first_next  = '0;
            end else begin
                if (offset_reg != '1) begin
                    offset_next = offset_reg + ADDR_W'(1);
                end
                if (hit) begin
                    seen_next  = 1'b1;
                    first_next = cand_addr;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            seen_reg   <= 1'b0;
            first_reg  <= '0;
        end else begin
            offset_reg <= offset_next;
            seen_reg   <= seen_next;
            first_reg  <= first_next;
        end
    end

    // ------------------------------------------------------------------
    // Result for the tlast byte, into the output buffer.
    // ------------------------------------------------------------------
    result_t res;
    result_t out_res;

    assign res.found         = seen_reg || hit;
    assign res.match_address = seen_reg ? first_reg : (hit ? cand_addr : '0);

    wbps_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid && s_tlast),
        .in_ready  (buf_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = OUT_TDATA_W'(out_res);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_no_addr_without_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[ADDR_W:1] == '0))
        else $error("result without match carries a nonzero address");

    a_region_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> ((offset_reg == '0) && !seen_reg && (first_reg == '0)))
        else $error("region state not cleared after last byte");

    a_match_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (seen_reg && !(s_fire && s_tlast)) |=> (seen_reg && $stable(first_reg)))
        else $error("first match lost or changed within a region");

    a_offset_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_tlast) |=> (offset_reg >= $past(offset_reg)))
        else $error("byte offset wrapped");

endmodule
